@@ hw/rtl/rcbm_pkg.sv @@
`timescale 1ns / 1ps
// rcbm_pkg: widths, capacity and controller states for row_count_below_mean
// no dependencies

package rcbm_pkg;

	localparam int ELEMENT_WIDTH = 16;
	localparam int MAX_COLUMNS   = 256;
	localparam int ADDR_W        = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int LEN_W         = 9;
	localparam int ROW_W         = 16;
	localparam int COUNT_W       = 9;
	localparam int SUM_OUT_W     = 24;
	localparam int SUM_W         = ELEMENT_WIDTH + LEN_W;
	localparam int CMP_W         = ELEMENT_WIDTH + LEN_W + 1;

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

endpackage

@@ hw/rtl/row_count_below_mean.sv @@
`timescale 1ns / 1ps
// row_count_below_mean: buffers each row, sums it, then rescans the buffer
// and counts elements with element * length < sum
// depends on rcbm_pkg and rcbm_row_ram
//
// the result strobe follows the last scan read through the buffer read register, the multiply register
// and the done register; no new row is accepted until the scan of the current one ends (busy high)
// the scan is set by the single read port of the row buffer, one entry a cycle
// reset: clears controller, row sum, column and row counters; length resets to 1
// the receiver cannot stall; done is high for exactly one cycle per row

module row_count_below_mean
	import rcbm_pkg::*;
(
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [ELEMENT_WIDTH-1:0] element,
	input  logic                            row_length_we,
	input  logic        [LEN_W-1:0]         row_length,
	output logic                            done,
	output logic        [ROW_W-1:0]         row_index,
	output logic        [COUNT_W-1:0]       below_count,
	output logic signed [SUM_OUT_W-1:0]     row_sum
);

	state_t                     state_q;
	logic [LEN_W-1:0]           row_length_q;
	logic [LEN_W-1:0]           eff_len;
	logic [LEN_W-1:0]           pos_q;
	logic signed [SUM_W-1:0]    running_sum_q;
	logic [ROW_W-1:0]           row_q;
	logic [COUNT_W-1:0]         count_q;
	logic [ADDR_W-1:0]          scan_q;
	logic                       issue_q;
	logic                       accept;
	logic                       scan_last;

	logic [ELEMENT_WIDTH-1:0]   rd_data;
	logic                       v_s1;
	logic                       last_s1;
	logic signed [CMP_W-1:0]    prod_s2;
	logic                       v_s2;
	logic                       last_s2;
	logic signed [CMP_W-1:0]    sum_ext;
	logic                       less;
	logic [COUNT_W-1:0]         count_next;

	logic                       done_q;
	logic [ROW_W-1:0]           row_index_q;
	logic [COUNT_W-1:0]         below_count_q;
	logic signed [SUM_OUT_W-1:0] row_sum_q;

	always_comb begin
		if (row_length_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (32'(row_length_q) > MAX_COLUMNS) begin
			eff_len = LEN_W'(MAX_COLUMNS);
		end else begin
			eff_len = row_length_q;
		end
	end

	assign busy       = (state_q != ST_LOAD);
	assign accept     = start && !busy;
	assign scan_last  = (LEN_W'(scan_q) == eff_len - LEN_W'(1));
	assign sum_ext    = CMP_W'(running_sum_q);
	assign less       = v_s2 && (prod_s2 < sum_ext);
	assign count_next = count_q + COUNT_W'(less);

	rcbm_row_ram #(
		.DEPTH  (MAX_COLUMNS),
		.DATA_W (ELEMENT_WIDTH),
		.ADDR_W (ADDR_W)
	) u_row_ram (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (ADDR_W'(pos_q)),
		.wr_data (element),
		.rd_en   (issue_q),
		.rd_addr (scan_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			row_length_q  <= LEN_W'(1);
			pos_q         <= '0;
			running_sum_q <= '0;
			row_q         <= '0;
			count_q       <= '0;
			scan_q        <= '0;
			issue_q       <= 1'b0;
			v_s1          <= 1'b0;
			last_s1       <= 1'b0;
			v_s2          <= 1'b0;
			last_s2       <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			v_s1    <= issue_q;
			last_s1 <= issue_q && scan_last;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			if (row_length_we) begin
				row_length_q  <= row_length;
				pos_q         <= '0;
				running_sum_q <= '0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						running_sum_q <= running_sum_q + SUM_W'(element);
						if (pos_q == eff_len - LEN_W'(1)) begin
							pos_q   <= '0;
							scan_q  <= '0;
							issue_q <= 1'b1;
							count_q <= '0;
							state_q <= ST_SCAN;
						end else begin
							pos_q <= pos_q + LEN_W'(1);
						end
					end
				end
				ST_SCAN: begin
					if (issue_q) begin
						if (scan_last) begin
							issue_q <= 1'b0;
						end else begin
							scan_q <= scan_q + ADDR_W'(1);
						end
					end
					if (v_s2) begin
						count_q <= count_next;
					end
					if (last_s2) begin
						done_q        <= 1'b1;
						row_q         <= row_q + ROW_W'(1);
						running_sum_q <= '0;
						count_q       <= '0;
						state_q       <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// multiply stage and result payload
	always_ff @(posedge clk) begin
		prod_s2 <= CMP_W'($signed(rd_data)) * CMP_W'($signed({1'b0, eff_len}));
		if (state_q == ST_SCAN && last_s2) begin
			row_index_q   <= row_q;
			below_count_q <= count_next;
			row_sum_q     <= running_sum_q[SUM_OUT_W-1:0];
		end
	end

	assign done        = done_q;
	assign row_index   = row_index_q;
	assign below_count = below_count_q;
	assign row_sum     = row_sum_q;

	a_done_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_SCAN))
		else $error("result strobe without a finished scan");

	a_pipe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(issue_q || v_s1 || v_s2) |-> busy)
		else $error("scan pipeline active while accepting elements");

	a_pos_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < eff_len)
		else $error("column position beyond row length");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (below_count < eff_len))
		else $error("below count not less than row length");

	a_load_no_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_LOAD) || issue_q)
		else $error("scan entered without issuing reads");

endmodule

@@ hw/rtl/rcbm_row_ram.sv @@
`timescale 1ns / 1ps
// rcbm_row_ram: simple dual port row buffer, one write and one registered read
// generic, no package dependencies

module rcbm_row_ram #(
	parameter int DEPTH  = 256,
	parameter int DATA_W = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
